/* rtl/swma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swma_pkg
// Shared types and fixed constants of the sliding window moving average.
// ----------------------------------------------------------------------------
package swma_pkg;

  localparam int WIN_W     = 9;   // window size register
  localparam int AVG_W     = 32;  // average output, Q15.16
  localparam int FRAC_BITS = 16;
  localparam int Q_DEPTH   = 2;   // front-to-back queue

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_UPD  = 2'b10
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_DONE = 3'b100
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/swma_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swma_ifs
// Valid/ready channels for sample beats and result beats.
// ----------------------------------------------------------------------------
interface swma_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swma_result_if #(
  parameter int HELD_W = 9
);
  logic                                   valid;
  logic                                   ready;
  logic signed [swma_pkg::AVG_W-1:0]      average;
  logic        [HELD_W-1:0]               samples_held;

  modport source (output valid, output average, output samples_held, input ready);
  modport sink   (input valid, input average, input samples_held, output ready);
endinterface

/* rtl/swma_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swma_front
// Accepts samples, keeps the sample ring and running sum, pushes sum/count.
// ----------------------------------------------------------------------------
module swma_front #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int PTR_W       = 8,
  parameter int HELD_W      = 9,
  parameter int SUM_W       = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [swma_pkg::WIN_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  input  swma_pkg::q_stat_t                 q_stat,
  output logic                              q_push,
  output logic signed [SUM_W-1:0]           q_sum,
  output logic [HELD_W-1:0]                 q_count
);

  localparam int CMP_W = (HELD_W > swma_pkg::WIN_W) ? HELD_W : swma_pkg::WIN_W;
  localparam int AW    = HELD_W + 1;

  logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];

  swma_pkg::front_state_t state_r, state_nxt;
  logic [swma_pkg::WIN_W-1:0]    window_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] old_r;
  logic                          drop_r;
  logic [PTR_W-1:0]              wr_r;
  logic [PTR_W-1:0]              oldest_r, oldest_nxt;
  logic [HELD_W-1:0]             fill_r, fill_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;

  logic              accept;
  logic [CMP_W-1:0]  w_ext, w_eff;
  logic              drop;
  logic [AW-1:0]     wr_raw, wr_wrap;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == swma_pkg::F_IDLE) && !q_stat.full;

  always_comb begin
    w_ext = CMP_W'(window_r);
    w_eff = w_ext;
    if (w_ext == '0) begin
      w_eff = CMP_W'(1);
    end else if (w_ext > CMP_W'(MAX_WINDOW)) begin
      w_eff = CMP_W'(MAX_WINDOW);
    end
    drop    = CMP_W'(fill_r) >= w_eff;
    wr_raw  = AW'(oldest_r) + AW'(fill_r);
    wr_wrap = (wr_raw >= AW'(MAX_WINDOW)) ? wr_raw - AW'(MAX_WINDOW) : wr_raw;
  end

  always_comb begin
    sum_nxt    = sum_r - (drop_r ? SUM_W'(old_r) : '0) + SUM_W'(sample_r);
    fill_nxt   = drop_r ? fill_r : fill_r + HELD_W'(1);
    oldest_nxt = oldest_r;
    if (drop_r) begin
      oldest_nxt = (oldest_r == PTR_W'(MAX_WINDOW - 1)) ? '0 : oldest_r + PTR_W'(1);
    end
    state_nxt = state_r;
    case (state_r)
      swma_pkg::F_IDLE: if (accept) state_nxt = swma_pkg::F_UPD;
      swma_pkg::F_UPD:  state_nxt = swma_pkg::F_IDLE;
      default:          state_nxt = swma_pkg::F_IDLE;
    endcase
  end

  assign q_push  = (state_r == swma_pkg::F_UPD);
  assign q_sum   = sum_nxt;
  assign q_count = fill_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= swma_pkg::F_IDLE;
      window_r <= swma_pkg::WIN_W'(1);
      oldest_r <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) window_r <= cfg_wdata;
      if (q_push) begin
        oldest_r <= oldest_nxt;
        fill_r   <= fill_nxt;
        sum_r    <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
      drop_r   <= drop;
      wr_r     <= wr_wrap[PTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    old_r <= ring[oldest_r];
    if (q_push) ring[wr_r] <= sample_r;
  end

endmodule

/* rtl/swma_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swma_queue
// Short FIFO of running sum and sample count between front and back.
// ----------------------------------------------------------------------------
module swma_queue #(
  parameter int HELD_W = 9,
  parameter int SUM_W  = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic signed [SUM_W-1:0] push_sum,
  input  logic [HELD_W-1:0]       push_count,
  input  logic                    pop,
  output logic signed [SUM_W-1:0] pop_sum,
  output logic [HELD_W-1:0]       pop_count,
  output swma_pkg::q_stat_t       stat
);

  localparam int QP_W = $clog2(swma_pkg::Q_DEPTH);
  localparam int QC_W = $clog2(swma_pkg::Q_DEPTH + 1);

  logic signed [SUM_W-1:0] sum_q [swma_pkg::Q_DEPTH];
  logic [HELD_W-1:0]       cnt_q [swma_pkg::Q_DEPTH];
  logic [QP_W-1:0]         wp_r, rp_r;
  logic [QC_W-1:0]         cnt_r;

  assign stat.full  = cnt_r == QC_W'(swma_pkg::Q_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign pop_sum    = sum_q[rp_r];
  assign pop_count  = cnt_q[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == QP_W'(swma_pkg::Q_DEPTH - 1)) ? '0 : wp_r + QP_W'(1);
      if (pop)  rp_r <= (rp_r == QP_W'(swma_pkg::Q_DEPTH - 1)) ? '0 : rp_r + QP_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + QC_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      sum_q[wp_r] <= push_sum;
      cnt_q[wp_r] <= push_count;
    end
  end

endmodule

/* rtl/swma_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swma_back
// Bit-serial divide of sum * 2^16 by count, sign fix-up, output register.
// ----------------------------------------------------------------------------
module swma_back #(
  parameter int HELD_W = 9,
  parameter int SUM_W  = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  swma_pkg::q_stat_t                 q_stat,
  output logic                              q_pop,
  input  logic signed [SUM_W-1:0]           q_sum,
  input  logic [HELD_W-1:0]                 q_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [swma_pkg::AVG_W-1:0] out_average,
  output logic [HELD_W-1:0]                 out_held
);

  localparam int DIV_W = SUM_W + swma_pkg::FRAC_BITS;
  localparam int IC_W  = $clog2(DIV_W + 1);
  localparam int EXT_W = DIV_W + swma_pkg::AVG_W + 1;

  swma_pkg::back_state_t state_r, state_nxt;
  logic [DIV_W-1:0]  dvd_r;
  logic [HELD_W-1:0] rem_r;
  logic [HELD_W-1:0] dvs_r;
  logic [HELD_W-1:0] held_r;
  logic              neg_r;
  logic [IC_W-1:0]   iter_r;
  logic              out_valid_r;
  logic signed [swma_pkg::AVG_W-1:0] avg_r;
  logic [HELD_W-1:0] out_held_r;

  logic [SUM_W-1:0]   mag;
  logic [HELD_W:0]    rem_sh, diff;
  logic               ge;
  logic signed [DIV_W:0] sq;
  logic signed [EXT_W-1:0] sq_ext;
  logic               load_out;

  assign q_pop    = (state_r == swma_pkg::B_IDLE) && !q_stat.empty;
  assign load_out = (state_r == swma_pkg::B_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    mag    = q_sum[SUM_W-1] ? SUM_W'(-q_sum) : SUM_W'(q_sum);
    rem_sh = {rem_r, dvd_r[DIV_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    ge     = rem_sh >= {1'b0, dvs_r};
    sq     = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
    sq_ext = EXT_W'(sq);
    state_nxt = state_r;
    case (state_r)
      swma_pkg::B_IDLE: if (q_pop) state_nxt = swma_pkg::B_DIV;
      swma_pkg::B_DIV:  if (iter_r == IC_W'(DIV_W - 1)) state_nxt = swma_pkg::B_DONE;
      swma_pkg::B_DONE: if (load_out) state_nxt = swma_pkg::B_IDLE;
      default:          state_nxt = swma_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swma_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dvd_r  <= {mag, swma_pkg::FRAC_BITS'(0)};
      rem_r  <= '0;
      dvs_r  <= q_count;
      held_r <= q_count;
      neg_r  <= q_sum[SUM_W-1];
      iter_r <= '0;
    end else if (state_r == swma_pkg::B_DIV) begin
      dvd_r  <= {dvd_r[DIV_W-2:0], ge};
      rem_r  <= ge ? diff[HELD_W-1:0] : rem_sh[HELD_W-1:0];
      iter_r <= iter_r + IC_W'(1);
    end
    if (load_out) begin
      avg_r      <= sq_ext[swma_pkg::AVG_W-1:0];
      out_held_r <= held_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = avg_r;
  assign out_held    = out_held_r;

endmodule

/* rtl/sliding_window_moving_average.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_moving_average
// Boxcar moving average over the last window_size samples, Q15.16 output.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one signed sample per beat (valid/ready).
//   out_chan : one beat per sample: window mean (Q15.16, truncated toward
//              zero) and the number of samples held after that sample.
//   cfg_we / cfg_wdata : window size, 0 acts as 1, above MAX_WINDOW clamps.
//              Write it while no sample is in flight.
// Timing:
//   The front reads the ring, then updates sum and ring, taking no sample
//   during the update, and pushes sum and count into a 2-entry queue. The
//   back pops an entry and runs a restoring divider, one quotient bit per
//   cycle over SAMPLE_BITS + log2(MAX_WINDOW) + 16 bits (40 at defaults),
//   then loads the output register. The divider loop limits the sample rate.
// Reset: window size 1, ring empty, sum zero, queue and output drained.
// Stall: a held result keeps the divider waiting; the queue then fills
//   and in_chan.ready drops until the result beat is taken.
// ----------------------------------------------------------------------------
module sliding_window_moving_average #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  swma_sample_if.sink                 in_chan,
  swma_result_if.source               out_chan,
  input  logic                        cfg_we,
  input  logic [swma_pkg::WIN_W-1:0]  cfg_wdata
);

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int HELD_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + PTR_W;

  swma_pkg::q_stat_t       q_stat;
  logic                    q_push, q_pop;
  logic signed [SUM_W-1:0] push_sum, pop_sum;
  logic [HELD_W-1:0]       push_count, pop_count;

  swma_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS),
    .PTR_W      (PTR_W),
    .HELD_W     (HELD_W),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_sample(in_chan.sample),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_sum    (push_sum),
    .q_count  (push_count)
  );

  swma_queue #(
    .HELD_W(HELD_W),
    .SUM_W (SUM_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_sum  (push_sum),
    .push_count(push_count),
    .pop       (q_pop),
    .pop_sum   (pop_sum),
    .pop_count (pop_count),
    .stat      (q_stat)
  );

  swma_back #(
    .HELD_W(HELD_W),
    .SUM_W (SUM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .q_sum      (pop_sum),
    .q_count    (pop_count),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_average(out_chan.average),
    .out_held   (out_chan.samples_held)
  );

endmodule

/* rtl/swma_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swma_checker
// Port-level checks of the moving average, bound to the top level.
// ----------------------------------------------------------------------------
module swma_checker #(
  parameter int MAX_WINDOW = 256,
  parameter int HELD_W     = 9
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [swma_pkg::AVG_W-1:0]  average,
  input logic [HELD_W-1:0]           samples_held
);

  logic [3:0] pend_r;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_beat && !out_beat) begin
      pend_r <= pend_r + 4'd1;
    end else if (out_beat && !in_beat) begin
      pend_r <= pend_r - 4'd1;
    end
  end

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(average) && $stable(samples_held))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat |-> pend_r != 4'd0)
    else $error("result beat without a pending sample");

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> samples_held != '0 && samples_held <= HELD_W'(MAX_WINDOW))
    else $error("samples_held out of range");

endmodule

bind sliding_window_moving_average swma_checker #(
  .MAX_WINDOW(MAX_WINDOW),
  .HELD_W    (HELD_W)
) u_swma_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .average     (out_chan.average),
  .samples_held(out_chan.samples_held)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the boxcar moving average. A tracker class keeps
// its own sample ring, running sum and fill count, and predicts the Q15.16
// mean and held count for each accepted sample beat. Result beats are
// checked in order. The window is rewritten between phases while the block
// is idle: zero and oversize values, growth and shrink while samples are
// held, and full-window extremes. The sender runs in bursts with gaps. The
// receiver stalls on a rotating pattern and once holds off long enough to
// back up the input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_WIN     = 256;
  localparam int SMP_W       = 16;
  localparam int HELD_W      = swma_pkg::WIN_W;
  localparam int PTR_W       = $clog2(MAX_WIN);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 100;

  class window_mean_tracker;
    typedef struct packed {
      logic signed [swma_pkg::AVG_W-1:0] average;
      logic        [HELD_W-1:0]          held;
    } mean_beat_t;

    logic signed [SMP_W-1:0] ring [MAX_WIN];
    logic [PTR_W-1:0]        oldest;
    logic [HELD_W-1:0]       held;
    int                      sum;
    logic [HELD_W-1:0]       window;
    mean_beat_t              due [$];
    int                      errors;

    function new();
      oldest = '0;
      held   = '0;
      sum    = 0;
      window = 1;
      errors = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void take_sample(logic signed [SMP_W-1:0] s);
      int unsigned      span;
      logic [PTR_W-1:0] slot;
      longint           scaled;
      mean_beat_t       beat;
      span = (window == 0) ? 1 : ((window > MAX_WIN) ? MAX_WIN : window);
      slot = oldest + held[PTR_W-1:0];
      if (held < span) begin
        held++;
      end else begin
        sum -= ring[oldest];
        oldest++;
      end
      ring[slot] = s;
      sum += s;
      scaled = (longint'(sum) * 65536) / longint'(held);
      beat.average = scaled[swma_pkg::AVG_W-1:0];
      beat.held    = held;
      due.push_back(beat);
    endfunction

    function void match_beat(logic signed [swma_pkg::AVG_W-1:0] avg,
                             logic [HELD_W-1:0] n);
      mean_beat_t want;
      if (due.size() == 0) begin
        $error("unexpected result beat: average %0d samples_held %0d", avg, n);
        errors++;
        return;
      end
      want = due.pop_front();
      if (avg !== want.average) begin
        $error("average: expected %0d, actual %0d", want.average, avg);
        errors++;
      end
      if (n !== want.held) begin
        $error("samples_held: expected %0d, actual %0d", want.held, n);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [HELD_W-1:0] cfg_wdata;
  bit                hold_req = 1'b0;
  int                cycle_count = 0;

  window_mean_tracker tracker = new();

  swma_sample_if #(.SAMPLE_BITS(SMP_W)) in_if ();
  swma_result_if #(.HELD_W(HELD_W))     out_if ();

  sliding_window_moving_average #(
    .MAX_WINDOW  (MAX_WIN),
    .SAMPLE_BITS (SMP_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sliding_window_moving_average test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      tracker.match_beat(out_if.average, out_if.samples_held);
    end
  end

  // receiver: rotating stall pattern, plus one long hold-off on request
  initial begin : receiver
    int unsigned tick;
    tick = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case (tick[9:8])
          2'd0: out_if.ready <= 1'b1;
          2'd1: out_if.ready <= ($urandom_range(0, 3) != 0);
          2'd2: out_if.ready <= (tick[2:0] < 3'd5);
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_beat(input logic signed [SMP_W-1:0] s);
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk); while (!in_if.ready);
    tracker.take_sample(s);
  endtask

  task automatic set_window(input logic [HELD_W-1:0] w);
    while (tracker.pending() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.window = w;
  endtask

  task automatic feed_list(input logic signed [SMP_W-1:0] vals [$]);
    foreach (vals[k]) send_beat(vals[k]);
    in_if.valid <= 1'b0;
  endtask

  task automatic feed_random(input int count, input int gap_max);
    int                      burst_left;
    int                      run_left;
    int                      gap;
    logic signed [SMP_W-1:0] run_val;
    logic signed [SMP_W-1:0] s;
    burst_left = $urandom_range(1, 16);
    run_left   = 0;
    run_val    = '0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 16);
      end
      // occasional long run of one extreme to push the mean to full scale
      if (run_left == 0 && $urandom_range(0, 399) == 0) begin
        run_left = $urandom_range(1, 300);
        run_val  = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      end
      if (run_left > 0) begin
        s = run_val;
        run_left--;
      end else begin
        case ($urandom_range(0, 9))
          0: s = 16'h8000;
          1: s = 16'h7fff;
          2: s = SMP_W'($urandom_range(0, 15) - 8);
          default: s = SMP_W'($urandom);
        endcase
      end
      send_beat(s);
      burst_left--;
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // zero acts as one
    set_window(0);
    feed_list('{16'h7fff, 16'h8000, 16'h0000});
    set_window(1);
    feed_list('{16'hffff, 16'h0001});
    // grow, fill and slide at both extremes
    set_window(3);
    feed_list('{16'h8000, 16'h8000, 16'h8000, 16'h8000,
                16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    // shrink while held: count stays
    set_window(2);
    feed_list('{16'h8000, 16'h8000});
    set_window(5);
    feed_list('{16'h7fff, 16'h7fff, 16'hffff, 16'h0000});

    set_window(17);
    feed_random(175, 12);
    set_window(HELD_W'($urandom_range(18, 60)));
    feed_random(175, 0);
    set_window(HELD_W'($urandom_range(61, 200)));
    hold_req = 1'b1;
    feed_random(175, 0);
    set_window(4);
    feed_random(175, 8);
    set_window(255);
    feed_random(175, 3);
    set_window(256);
    for (int k = 0; k < MAX_WIN; k++) send_beat(16'h8000);
    for (int k = 0; k < MAX_WIN; k++) send_beat(16'h7fff);
    feed_random(175, 12);
    set_window(511);
    feed_random(175, 0);
    set_window(HELD_W'($urandom_range(0, 511)));
    feed_random(175, 6);

    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("sliding_window_moving_average test passed");
    end else begin
      $display("sliding_window_moving_average test failed");
    end
    $finish;
  end

endmodule

/* sliding_window_moving_average.f */
rtl/swma_pkg.sv
rtl/swma_ifs.sv
rtl/swma_front.sv
rtl/swma_queue.sv
rtl/swma_back.sv
rtl/sliding_window_moving_average.sv
rtl/swma_checker.sv
bench/tb_top.sv
